// ----- hdl/ps2md_pkg.sv -----
package ps2md_pkg;

  // Controller byte
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned UsrReady = 0;   // tuser bit: output-full flag
  localparam int unsigned UsrAux   = 1;   // tuser bit: auxiliary-source flag

  // Header byte bits
  localparam int unsigned HdrSyncBit = 3;
  localparam int unsigned HdrXOvfBit = 6;
  localparam int unsigned HdrYOvfBit = 7;
  localparam int unsigned BtnW       = 3;

  // Wheel nibble and result fields
  localparam int unsigned WheelW  = 4;
  localparam int unsigned CursorW = 32;
  localparam int unsigned OutW    = 2 * CursorW + BtnW + WheelW;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  // Byte position inside a packet
  localparam int unsigned IdxW = 2;
  typedef logic [IdxW-1:0] idx_t;
  localparam idx_t IdxHdr   = 2'd0;
  localparam idx_t IdxX     = 2'd1;
  localparam idx_t IdxY     = 2'd2;
  localparam idx_t IdxWheel = 2'd3;

  // Register file
  localparam int unsigned ApbAddrW = 2;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] AddrWheelMode = 2'd0;

endpackage

// ----- hdl/ps2_mouse_packet_decoder_core.sv -----
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tdata: data_byte; tuser: byte_ready, from_aux
// m_axis    out  m_axis_tvalid/tready   tdata: cursor_x, cursor_y, buttons, scroll_rows
// apb       in   psel/penable/pready    wheel_mode at byte address 0
//
// One byte per cycle sustained while the output is not stalled. An accepted
// byte lands in the input register, is decoded against the packet state and,
// when it closes a packet, its result lands in the output register, which
// drives m_axis_tvalid. The output register is the only stall point; while it
// is full and not taken, the input register holds one more byte. Reset clears
// the packet position, the totals, the buttons and the mode; no clearing pass.
module ps2_mouse_packet_decoder_core #(
  parameter int unsigned POS_WIDTH    = 32,
  parameter int unsigned SCROLL_LIMIT = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Byte stream from the controller
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ps2md_pkg::ByteW-1:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic [ps2md_pkg::InUserW-1:0]        s_axis_tuser,   // [0] byte_ready, [1] from_aux
  // Decoded packets
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [31:0] cursor_x, [63:32] cursor_y, [66:64] buttons, [70:67] scroll_rows, [71] zero
  output logic [ps2md_pkg::OutBytesW-1:0]      m_axis_tdata,
  // Register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ps2md_pkg::ApbAddrW-1:0]       paddr,
  input  logic [ps2md_pkg::ApbDataW-1:0]       pwdata,
  output logic [ps2md_pkg::ApbDataW-1:0]       prdata,
  output logic                                 pready
);

  // Totals are sign-extended to at least the reported width before the low
  // bits are taken.
  localparam int unsigned ExtW = (POS_WIDTH > ps2md_pkg::CursorW) ?
                                 POS_WIDTH : ps2md_pkg::CursorW;
  localparam logic signed [ps2md_pkg::WheelW-1:0] ScrollMax =
    ps2md_pkg::WheelW'(SCROLL_LIMIT);
  localparam logic signed [ps2md_pkg::WheelW-1:0] ScrollMin = -ScrollMax;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic wheel_mode_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == ps2md_pkg::AddrWheelMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      wheel_mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ps2md_pkg::AddrWheelMode) begin
      prdata[0] = wheel_mode_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                          in_v_q;
  logic [ps2md_pkg::ByteW-1:0]   in_byte_q;
  logic [ps2md_pkg::InUserW-1:0] in_user_q;
  logic                          advance;   // decode stage may move this cycle
  logic                          process;   // byte in input register is decoded now
  logic                          s_fire;

  assign advance       = !(m_axis_tvalid && !m_axis_tready);
  assign process       = in_v_q && advance;
  assign s_axis_tready = !in_v_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Packet decode
  // ---------------------------------------------------------------------------
  ps2md_pkg::idx_t               idx_q, idx_d;
  logic [ps2md_pkg::ByteW-1:0]   hdr_q, bx_q, by_q;   // stored packet bytes
  logic signed [POS_WIDTH-1:0]   x_tot_q, x_tot_d;
  logic signed [POS_WIDTH-1:0]   y_tot_q, y_tot_d;
  logic [ps2md_pkg::BtnW-1:0]    btn_q, btn_d;

  logic                          byte_ok;
  logic                          in_sync;
  ps2md_pkg::idx_t               last_idx;
  logic                          store_byte;
  logic                          pkt_done;
  logic [ps2md_pkg::ByteW-1:0]   by_sel;
  logic signed [POS_WIDTH-1:0]   dx, dy;
  logic signed [ps2md_pkg::WheelW-1:0] wheel_raw, rows;

  assign byte_ok  = in_user_q[ps2md_pkg::UsrReady] && in_user_q[ps2md_pkg::UsrAux];
  // Out of sync: a header candidate without the always-one bit is dropped
  assign in_sync  = (idx_q != ps2md_pkg::IdxHdr) || in_byte_q[ps2md_pkg::HdrSyncBit];
  assign last_idx = wheel_mode_q ? ps2md_pkg::IdxWheel : ps2md_pkg::IdxY;

  assign store_byte = process && byte_ok && in_sync && (idx_q < last_idx);
  assign pkt_done   = process && byte_ok && in_sync && (idx_q >= last_idx);

  // Y comes from this byte in three-byte mode; in wheel mode (or after the
  // mode was dropped mid-packet) it was stored earlier.
  assign by_sel = (idx_q == ps2md_pkg::IdxY) ? in_byte_q : by_q;

  assign dx = hdr_q[ps2md_pkg::HdrXOvfBit] ? '0 : POS_WIDTH'($signed(bx_q));
  assign dy = hdr_q[ps2md_pkg::HdrYOvfBit] ? '0 : POS_WIDTH'($signed(by_sel));

  assign x_tot_d = pkt_done ? x_tot_q + dx : x_tot_q;
  assign y_tot_d = pkt_done ? y_tot_q - dy : y_tot_q;
  assign btn_d   = pkt_done ? hdr_q[ps2md_pkg::BtnW-1:0] : btn_q;

  always_comb begin
    idx_d = idx_q;
    if (pkt_done) begin
      idx_d = ps2md_pkg::IdxHdr;
    end else if (store_byte) begin
      idx_d = idx_q + ps2md_pkg::idx_t'(1);
    end
  end

  // Wheel nibble, clamped to the scroll limit; zero outside wheel mode
  assign wheel_raw = $signed(in_byte_q[ps2md_pkg::WheelW-1:0]);
  always_comb begin
    rows = wheel_raw;
    if (wheel_raw > ScrollMax) begin
      rows = ScrollMax;
    end else if (wheel_raw < ScrollMin) begin
      rows = ScrollMin;
    end
    if (!wheel_mode_q) begin
      rows = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= ps2md_pkg::IdxHdr;
      x_tot_q <= '0;
      y_tot_q <= '0;
      btn_q   <= '0;
    end else begin
      idx_q   <= idx_d;
      x_tot_q <= x_tot_d;
      y_tot_q <= y_tot_d;
      btn_q   <= btn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_byte) begin
      case (idx_q)
        ps2md_pkg::IdxHdr: begin
          hdr_q <= in_byte_q;
        end
        ps2md_pkg::IdxX: begin
          bx_q <= in_byte_q;
        end
        ps2md_pkg::IdxY: begin
          by_q <= in_byte_q;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [ExtW-1:0]              x_ext, y_ext;
  logic [ps2md_pkg::OutBytesW-1:0]     out_data_q;
  logic                                out_v_q;

  assign x_ext = ExtW'(x_tot_d);
  assign y_ext = ExtW'(y_tot_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= pkt_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_done) begin
      out_data_q <= ps2md_pkg::OutBytesW'({rows, btn_d,
                                           y_ext[ps2md_pkg::CursorW-1:0],
                                           x_ext[ps2md_pkg::CursorW-1:0]});
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A result only shows up after a byte was decoded
  a_result_from_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(in_v_q))
    else $error("result without a decoded byte");

  // A finished packet restarts at the header
  a_done_resyncs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_done |=> (idx_q == ps2md_pkg::IdxHdr))
    else $error("byte position not cleared after a packet");

  // While the output is stalled, the totals stay put
  a_stall_holds_totals : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(x_tot_q) && $stable(y_tot_q)))
    else $error("totals moved during an output stall");

endmodule
